// ===== rtl/ps2kc_pkg.sv =====
// ----------------------------------------------------------------------------
// ps2kc_pkg
// Shared types, codes and the set 2 to set 1 translation table.
// ----------------------------------------------------------------------------
package ps2kc_pkg;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [7:0] CMD_GET_CB   = 8'h20;
  localparam logic [7:0] CMD_SET_CB   = 8'h60;
  localparam logic [7:0] CMD_MDIS     = 8'ha7;
  localparam logic [7:0] CMD_MEN      = 8'ha8;
  localparam logic [7:0] CMD_MTEST    = 8'ha9;
  localparam logic [7:0] CMD_SELFTEST = 8'haa;
  localparam logic [7:0] CMD_KTEST    = 8'hab;
  localparam logic [7:0] CMD_KDIS     = 8'had;
  localparam logic [7:0] CMD_KEN      = 8'hae;
  localparam logic [7:0] CMD_TO_MOUSE = 8'hd4;
  localparam logic [7:0] CMD_RESET    = 8'hfe;

  localparam logic [7:0] BREAK_PREFIX = 8'hf0;
  localparam logic [7:0] BREAK_BIT    = 8'h80;
  localparam logic [7:0] SELFTEST_OK  = 8'h55;
  localparam logic [7:0] TEST_FAIL    = 8'h02;

  localparam int ST_OBF  = 0;
  localparam int ST_IBF  = 1;
  localparam int ST_CMD  = 3;
  localparam int ST_AOBF = 5;
  localparam int ST_PERR = 7;

  localparam int CB_KIRQ = 0;
  localparam int CB_MIRQ = 1;
  localparam int CB_KDIS = 4;
  localparam int CB_MDIS = 5;
  localparam int CB_XLAT = 6;

  localparam logic [7:0] STATUS_RST  = 8'h14;
  localparam logic [7:0] COMMAND_RST = 8'h67;
  localparam logic [2:0] PKT_RST     = 3'd3;

  typedef struct packed {
    logic [7:0] read_data;
    logic       kbd_taken;
    logic       mouse_taken;
    logic       send_valid;
    logic       send_to_mouse;
    logic [7:0] send_byte;
    logic       kbd_irq;
    logic       mouse_irq;
    logic [7:0] command_byte_out;
    logic       reset_request;
  } result_t;

  localparam logic [7:0] XLAT_ROM [0:135] = '{
    8'hff, 8'h43, 8'h41, 8'h3f, 8'h3d, 8'h3b, 8'h3c, 8'h58,
    8'h64, 8'h44, 8'h42, 8'h40, 8'h3e, 8'h0f, 8'h29, 8'h59,
    8'h65, 8'h38, 8'h2a, 8'h70, 8'h1d, 8'h10, 8'h02, 8'h5a,
    8'h66, 8'h71, 8'h2c, 8'h1f, 8'h1e, 8'h11, 8'h03, 8'h5b,
    8'h67, 8'h2e, 8'h2d, 8'h20, 8'h12, 8'h05, 8'h04, 8'h5c,
    8'h68, 8'h39, 8'h2f, 8'h21, 8'h14, 8'h13, 8'h06, 8'h5d,
    8'h69, 8'h31, 8'h30, 8'h23, 8'h22, 8'h15, 8'h07, 8'h5e,
    8'h6a, 8'h72, 8'h32, 8'h24, 8'h16, 8'h08, 8'h09, 8'h5f,
    8'h6b, 8'h33, 8'h25, 8'h17, 8'h18, 8'h0b, 8'h0a, 8'h60,
    8'h6c, 8'h34, 8'h35, 8'h26, 8'h27, 8'h19, 8'h0c, 8'h61,
    8'h6d, 8'h73, 8'h28, 8'h74, 8'h1a, 8'h0d, 8'h62, 8'h6e,
    8'h3a, 8'h36, 8'h1c, 8'h1b, 8'h75, 8'h2b, 8'h63, 8'h76,
    8'h55, 8'h56, 8'h77, 8'h78, 8'h79, 8'h7a, 8'h0e, 8'h7b,
    8'h7c, 8'h4f, 8'h7d, 8'h4b, 8'h47, 8'h7e, 8'h7f, 8'h6f,
    8'h52, 8'h53, 8'h50, 8'h4c, 8'h4d, 8'h48, 8'h01, 8'h45,
    8'h57, 8'h4e, 8'h51, 8'h4a, 8'h37, 8'h49, 8'h46, 8'h54,
    8'h80, 8'h81, 8'h82, 8'h41, 8'h54, 8'h85, 8'h86, 8'h87
  };

  function automatic logic [7:0] translate(input logic [7:0] code);
    logic [7:0] r;
    r = code;
    if (code < 8'd136) r = XLAT_ROM[code];
    return r;
  endfunction

endpackage

// ===== rtl/ps2kc_core.sv =====
// ----------------------------------------------------------------------------
// ps2kc_core
// Controller state and the per-item update: host access, scancode and mouse
// byte intake, command execution, device send and interrupt counting.
// ----------------------------------------------------------------------------
module ps2kc_core #(
  parameter int IRQ_COUNT_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [2:0]            pkt_bytes,
  input  logic [1:0]            opcode,
  input  logic                  port,
  input  logic [7:0]            write_data,
  input  logic                  kbd_valid,
  input  logic [7:0]            kbd_code,
  input  logic                  mouse_valid,
  input  logic [31:0]           mouse_packet,
  input  logic                  kbd_present,
  input  logic                  mouse_present,
  input  logic                  kbd_parity_err,
  input  logic [1:0]            irq_accept,
  output ps2kc_pkg::result_t    res
);
  import ps2kc_pkg::*;

  localparam logic [IRQ_COUNT_BITS-1:0] CNT_MAX = '1;

  logic [7:0]  status_r, status_nxt;
  logic [7:0]  obuf_r, obuf_nxt;
  logic [7:0]  ibuf_r, ibuf_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic        route_r, route_nxt;
  logic [31:0] hold_r, hold_nxt;
  logic [2:0]  pidx_r, pidx_nxt;
  logic [IRQ_COUNT_BITS-1:0] kcnt_r, kcnt_nxt, mcnt_r, mcnt_nxt;

  logic [2:0] size;
  logic [7:0] sc, cmd_code;
  logic [2:0] pinc;
  logic       rst_hit;

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= STATUS_RST;
      obuf_r   <= '0;
      ibuf_r   <= '0;
      cmd_r    <= COMMAND_RST;
      pend_r   <= '0;
      route_r  <= 1'b0;
      hold_r   <= '0;
      pidx_r   <= '0;
      kcnt_r   <= '0;
      mcnt_r   <= '0;
    end else if (step) begin
      status_r <= status_nxt;
      obuf_r   <= obuf_nxt;
      ibuf_r   <= ibuf_nxt;
      cmd_r    <= cmd_nxt;
      pend_r   <= pend_nxt;
      route_r  <= route_nxt;
      hold_r   <= hold_nxt;
      pidx_r   <= pidx_nxt;
      kcnt_r   <= kcnt_nxt;
      mcnt_r   <= mcnt_nxt;
    end
  end

  // compute next state and result
  always_comb begin
    status_nxt = status_r;
    obuf_nxt   = obuf_r;
    ibuf_nxt   = ibuf_r;
    cmd_nxt    = cmd_r;
    pend_nxt   = pend_r;
    route_nxt  = route_r;
    hold_nxt   = hold_r;
    pidx_nxt   = pidx_r;
    kcnt_nxt   = kcnt_r;
    mcnt_nxt   = mcnt_r;
    res        = '0;
    size       = (pkt_bytes < 3'd3) ? 3'd3 : ((pkt_bytes > 3'd4) ? 3'd4 : pkt_bytes);
    sc         = translate(kbd_code);
    cmd_code   = '0;
    pinc       = '0;
    rst_hit    = 1'b0;

    case (opcode)
      OP_READ: begin
        if (!port) begin
          status_nxt[ST_OBF]  = 1'b0;
          status_nxt[ST_AOBF] = 1'b0;
          res.read_data = obuf_r;
        end else begin
          res.read_data = status_r;
        end
      end
      OP_WRITE: begin
        ibuf_nxt = write_data;
        status_nxt[ST_IBF] = 1'b1;
        status_nxt[ST_CMD] = port;
      end
      OP_TICK: begin
        // keyboard scancode intake
        if (!status_nxt[ST_OBF] && kbd_valid) begin
          res.kbd_taken = 1'b1;
          if (cmd_r[CB_XLAT]) begin
            obuf_nxt = (obuf_r == BREAK_PREFIX) ? (BREAK_BIT | sc) : sc;
            if (sc != BREAK_PREFIX) begin
              status_nxt[ST_OBF] = 1'b1;
              if (kcnt_nxt != CNT_MAX) kcnt_nxt = kcnt_nxt + 1'b1;
            end
          end else begin
            obuf_nxt = kbd_code;
            status_nxt[ST_OBF] = 1'b1;
            if (kcnt_nxt != CNT_MAX) kcnt_nxt = kcnt_nxt + 1'b1;
          end
        end
        // mouse byte delivery
        if (!status_nxt[ST_OBF] && (pidx_r != 3'd0 || mouse_valid)) begin
          if (pidx_r == 3'd0) begin
            hold_nxt = mouse_packet;
            res.mouse_taken = 1'b1;
          end
          obuf_nxt = hold_nxt[pidx_r[1:0]*8 +: 8];
          pinc = pidx_r + 3'd1;
          pidx_nxt = (pinc >= size) ? 3'd0 : pinc;
          status_nxt[ST_OBF]  = 1'b1;
          status_nxt[ST_AOBF] = 1'b1;
          if (mcnt_nxt != CNT_MAX) mcnt_nxt = mcnt_nxt + 1'b1;
        end
        // command execution; at most one of the two paths runs
        if (status_nxt[ST_CMD] || (status_nxt[ST_IBF] && pend_r != 8'd0)) begin
          status_nxt[ST_IBF] = 1'b0;
          status_nxt[ST_CMD] = 1'b0;
          cmd_code = (pend_r == 8'd0) ? ibuf_r : pend_r;
          case (cmd_code)
            CMD_GET_CB: begin
              obuf_nxt = cmd_r;
              status_nxt[ST_OBF] = 1'b1;
            end
            CMD_SET_CB: begin
              if (pend_r != 8'd0) begin
                cmd_nxt  = ibuf_r;
                pend_nxt = '0;
              end else begin
                pend_nxt = CMD_SET_CB;
              end
            end
            CMD_MDIS: cmd_nxt[CB_MDIS] = 1'b1;
            CMD_MEN:  cmd_nxt[CB_MDIS] = 1'b0;
            CMD_MTEST: begin
              obuf_nxt = mouse_present ? 8'h00 : TEST_FAIL;
              status_nxt[ST_OBF] = 1'b1;
            end
            CMD_SELFTEST: begin
              obuf_nxt = SELFTEST_OK;
              status_nxt[ST_OBF] = 1'b1;
            end
            CMD_KTEST: begin
              obuf_nxt = kbd_present ? 8'h00 : TEST_FAIL;
              status_nxt[ST_OBF] = 1'b1;
            end
            CMD_KDIS:     cmd_nxt[CB_KDIS] = 1'b1;
            CMD_KEN:      cmd_nxt[CB_KDIS] = 1'b0;
            CMD_TO_MOUSE: route_nxt = 1'b1;
            CMD_RESET:    rst_hit = 1'b1;
            default: ;
          endcase
        end
        // forward a data byte to a device
        if (status_nxt[ST_IBF]) begin
          status_nxt[ST_IBF]  = 1'b0;
          status_nxt[ST_PERR] = kbd_parity_err;
          res.send_valid    = 1'b1;
          res.send_to_mouse = route_nxt;
          res.send_byte     = ibuf_r;
          route_nxt         = 1'b0;
        end
        // raise or drop pending interrupts
        if (kcnt_nxt != '0) begin
          if (cmd_nxt[CB_KIRQ]) begin
            res.kbd_irq = 1'b1;
            if (irq_accept[0]) kcnt_nxt = kcnt_nxt - 1'b1;
          end else begin
            kcnt_nxt = kcnt_nxt - 1'b1;
          end
        end
        if (mcnt_nxt != '0) begin
          if (cmd_nxt[CB_MIRQ]) begin
            res.mouse_irq = 1'b1;
            if (irq_accept[1]) mcnt_nxt = mcnt_nxt - 1'b1;
          end else begin
            mcnt_nxt = mcnt_nxt - 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.reset_request    = rst_hit;
    res.command_byte_out = cmd_nxt;
  end

endmodule

// ===== rtl/ps2_keyboard_controller.sv =====
// ----------------------------------------------------------------------------
// ps2_keyboard_controller
// Host side of an 8042 style keyboard and mouse controller.
// ----------------------------------------------------------------------------
// One item (host read, host write, or tick) is taken per clock while in_stall
// is low. The state update and the result are computed combinationally from
// the controller registers; the result lands in an output register with a skid
// stage, so a new item is accepted every cycle while the result side keeps up;
// while the output is stalled, an accepted item's result waits in the skid stage.
module ps2_keyboard_controller #(
  parameter int IRQ_COUNT_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_mouse_packet_bytes,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic        in_port,
  input  logic [7:0]  in_write_data,
  input  logic        in_kbd_valid,
  input  logic [7:0]  in_kbd_code,
  input  logic        in_mouse_valid,
  input  logic [31:0] in_mouse_packet,
  input  logic        in_kbd_present,
  input  logic        in_mouse_present,
  input  logic        in_kbd_parity_err,
  input  logic [1:0]  in_irq_accept,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic        out_kbd_taken,
  output logic        out_mouse_taken,
  output logic        out_send_valid,
  output logic        out_send_to_mouse,
  output logic [7:0]  out_send_byte,
  output logic        out_kbd_irq,
  output logic        out_mouse_irq,
  output logic [7:0]  out_command_byte_out,
  output logic        out_reset_request
);
  import ps2kc_pkg::*;

  logic [2:0] pkt_r;
  logic       step;
  result_t    res, main_r, skid_r;
  logic       mv_r, sv_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = sv_r;
  assign step      = in_valid && !sv_r;

  // hold configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_r <= PKT_RST;
    end else if (cfg_valid) begin
      pkt_r <= cfg_mouse_packet_bytes;
    end
  end

  ps2kc_core #(.IRQ_COUNT_BITS(IRQ_COUNT_BITS)) u_core (
    .clk, .rst_n, .step,
    .pkt_bytes(pkt_r),
    .opcode(in_opcode), .port(in_port), .write_data(in_write_data),
    .kbd_valid(in_kbd_valid), .kbd_code(in_kbd_code),
    .mouse_valid(in_mouse_valid), .mouse_packet(in_mouse_packet),
    .kbd_present(in_kbd_present), .mouse_present(in_mouse_present),
    .kbd_parity_err(in_kbd_parity_err), .irq_accept(in_irq_accept),
    .res
  );

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
      sv_r <= 1'b0;
    end else begin
      if (!mv_r || !out_stall) begin
        mv_r <= sv_r || step;
        sv_r <= 1'b0;
      end else if (step) begin
        sv_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!mv_r || !out_stall) begin
      main_r <= sv_r ? skid_r : res;
    end
    if (step && mv_r && out_stall) begin
      skid_r <= res;
    end
  end

  assign out_valid            = mv_r;
  assign out_read_data        = main_r.read_data;
  assign out_kbd_taken        = main_r.kbd_taken;
  assign out_mouse_taken      = main_r.mouse_taken;
  assign out_send_valid       = main_r.send_valid;
  assign out_send_to_mouse    = main_r.send_to_mouse;
  assign out_send_byte        = main_r.send_byte;
  assign out_kbd_irq          = main_r.kbd_irq;
  assign out_mouse_irq        = main_r.mouse_irq;
  assign out_command_byte_out = main_r.command_byte_out;
  assign out_reset_request    = main_r.reset_request;

`ifndef SYNTH
  // skid holds a word only while the main register is full
  a_skid_main: assert property (@(posedge clk) disable iff (!rst_n) sv_r |-> mv_r)
    else $error("skid full with empty output register");
  // after an accepted item the output register holds a valid word next cycle
  a_step_out: assert property (@(posedge clk) disable iff (!rst_n) step |=> mv_r)
    else $error("accepted item produced no result");
  // a send word carries no target or byte when no send
  a_send_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (mv_r && !out_send_valid) |-> (!out_send_to_mouse && out_send_byte == 8'd0))
    else $error("send fields set without send");
`endif

endmodule
